// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define MRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define MRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mrb_pkg.sv =====
// Shared types and constants of the largest-rectangle block.
`default_nettype none
package mrb_pkg;
  localparam int OUT_W  = 13;
  localparam int REG_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_COLUMNS = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_ROWS    = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/max_rectangle_binary_image.sv =====
// Largest all-ones rectangle in a binary image: top level.
// Usage:
//   Pixels enter on in_valid/in_stall/in_pixel in raster order. A transaction
//   takes place at a rising edge with valid high and stall low.
//   After the last pixel of a frame one result leaves on out_valid/out_stall/
//   out_largest_area, the pixel count of the largest all-ones rectangle.
//   The frame size is set through the APB port: columns_in_use at 0x0,
//   rows_in_use at 0x4; a write clears the current frame.
// Each pixel goes through a column-height memory read, an update, then one
//   compare per stack step in the cell chain; in_stall stays high until it is
//   done. The end of a row pops every entry left on the stack.
// The result is registered at the end of the row flush of the last row.
// Reset clears the positions, stack depth, best area and the valid marks of all
//   column heights, and sets both sizes to 64 (capped at the maximum).
// While the receiver stalls a result, it holds; the block keeps taking pixels
//   and waits only if the next frame ends before the result leaves.
`default_nettype none
`include "assert_macros.svh"
module max_rectangle_binary_image #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_pixel,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mrb_pkg::OUT_W-1:0]         out_largest_area,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mrb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mrb_pkg::DATA_W-1:0]   pwdata,
  output logic [mrb_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import mrb_pkg::*;

  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int IW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int NCELL = MAX_COLUMNS + 1;
  localparam int DW    = $clog2(NCELL + 1);
  localparam int EW    = HW + CW;
  localparam int AW    = HW + CW;
  localparam int CDEF  = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;
  localparam int RDEF  = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_POP, S_FLUSH} state_t;

  state_t           state_r;
  logic [REG_W-1:0] cols_r;
  logic [REG_W-1:0] rows_r;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [DW-1:0]    depth_r;
  logic [AW-1:0]    best_r;
  logic [HW-1:0]    h_r;
  logic [CW-1:0]    start_r;
  logic             pix_r;
  logic [HW-1:0]    rd_r;
  logic             rd_vld_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_area_r;
  logic [MAX_COLUMNS-1:0] vld_r;
  logic [HW-1:0]    ht_mem [MAX_COLUMNS];

  logic             cfg_wr;
  logic             cfg_hit;
  logic [REG_W-1:0] cfg_val;
  logic             in_acc;
  logic [IW-1:0]    col_idx;
  logic [HW-1:0]    h_c;
  logic [HW-1:0]    h_old;
  logic [CW-1:0]    cols_c;
  logic [RW-1:0]    rows_c;
  logic [EW-1:0]    q [NCELL];
  logic [HW-1:0]    top_h;
  logic [CW-1:0]    top_s;
  logic [CW-1:0]    mul_w;
  logic [AW-1:0]    area_c;
  logic             pop_ok;
  logic             row_end;
  logic             frame_end;
  logic             out_free;
  logic             out_load;
  stk_cmd_t         cmd;

  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_hit  = cfg_wr && (paddr == ADDR_COLUMNS || paddr == ADDR_ROWS);
  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    priority if (pwdata[REG_W-1:0] == '0) begin
      cfg_val = REG_W'(1);
    end else begin
      cfg_val = pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_COLUMNS: prdata = DATA_W'(cols_r);
      ADDR_ROWS:    prdata = DATA_W'(rows_r);
      default:      prdata = '0;
    endcase
  end

  assign cols_c  = CW'(cols_r);
  assign rows_c  = RW'(rows_r);
  assign col_idx = col_r[IW-1:0];
  assign top_h   = q[0][EW-1:CW];
  assign top_s   = q[0][CW-1:0];
  assign h_old   = rd_vld_r ? rd_r : '0;

  always_comb begin
    priority if (!pix_r) begin
      h_c = '0;
    end else if (32'(h_old) < 32'(MAX_ROWS)) begin
      h_c = h_old + HW'(1);
    end else begin
      h_c = h_old;
    end
  end

  assign mul_w  = (state_r == S_FLUSH) ? (cols_c - top_s) : (col_r - top_s);
  assign area_c = AW'(top_h) * AW'(mul_w);
  assign pop_ok = (depth_r != '0) && (top_h >= h_r);
  assign row_end   = ({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, cols_c};
  assign frame_end = ({1'b0, row_r} + (RW+1)'(1)) >= {1'b0, rows_c};
  assign out_load  = !cfg_hit && (state_r == S_FLUSH) && (depth_r == '0) &&
                     frame_end && out_free;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_POP: begin
        cmd.pop  = pop_ok;
        cmd.push = !pop_ok;
      end
      S_FLUSH: cmd.pop = (depth_r != '0);
      default: cmd = '0;
    endcase
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [EW-1:0] up;
    logic [EW-1:0] dn;
    if (i == 0) begin : g_top
      assign up = {h_r, start_r};
    end else begin : g_mid
      assign up = q[i-1];
    end
    if (i == NCELL - 1) begin : g_bot
      assign dn = '0;
    end else begin : g_dn
      assign dn = q[i+1];
    end
    mrb_cell #(.EW(EW)) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .up_i (up),
      .dn_i (dn),
      .q_o  (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r  <= ht_mem[col_idx];
      pix_r <= in_pixel;
    end
    if (state_r == S_LOAD) begin
      ht_mem[col_idx] <= h_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cols_r      <= REG_W'(CDEF);
      rows_r      <= REG_W'(RDEF);
      col_r       <= '0;
      row_r       <= '0;
      depth_r     <= '0;
      best_r      <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        if (paddr == ADDR_COLUMNS) begin
          cols_r <= (32'(cfg_val) > 32'(MAX_COLUMNS)) ? REG_W'(MAX_COLUMNS) : cfg_val;
        end else begin
          rows_r <= (32'(cfg_val) > 32'(MAX_ROWS)) ? REG_W'(MAX_ROWS) : cfg_val;
        end
        state_r <= S_IDLE;
        col_r   <= '0;
        row_r   <= '0;
        depth_r <= '0;
        best_r  <= '0;
        vld_r   <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_acc) begin
              rd_vld_r <= vld_r[col_idx];
              state_r  <= S_LOAD;
            end
          end
          S_LOAD: begin
            h_r            <= h_c;
            start_r        <= col_r;
            vld_r[col_idx] <= 1'b1;
            state_r        <= S_POP;
          end
          S_POP: begin
            if (pop_ok) begin
              if (area_c > best_r) begin
                best_r <= area_c;
              end
              start_r <= top_s;
              depth_r <= depth_r - DW'(1);
            end else begin
              depth_r <= depth_r + DW'(1);
              if (row_end) begin
                state_r <= S_FLUSH;
              end else begin
                col_r   <= col_r + CW'(1);
                state_r <= S_IDLE;
              end
            end
          end
          S_FLUSH: begin
            if (depth_r != '0) begin
              if (area_c > best_r) begin
                best_r <= area_c;
              end
              depth_r <= depth_r - DW'(1);
            end else if (!frame_end) begin
              col_r   <= '0;
              row_r   <= row_r + RW'(1);
              state_r <= S_IDLE;
            end else if (out_free) begin
              out_valid_r <= 1'b1;
              out_area_r  <= OUT_W'(best_r);
              col_r       <= '0;
              row_r       <= '0;
              best_r      <= '0;
              vld_r       <= '0;
              state_r     <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_largest_area = out_area_r;

  `MRB_ASSERT_IMP(a_depth_bound, 1'b1, 32'(depth_r) <= NCELL)
  `MRB_ASSERT_NXT(a_acc_load, in_acc && !cfg_wr, state_r == S_LOAD)
  `MRB_ASSERT_IMP(a_out_empty, $rose(out_valid_r), depth_r == '0 && best_r == '0)
endmodule
`default_nettype wire

// ===== rtl/mrb_cell.sv =====
// One stack cell: holds an entry and shifts with its neighbors on push and pop.
`default_nettype none
module mrb_cell #(
  parameter int EW = 13
) (
  input  wire logic             clk,
  input  wire mrb_pkg::stk_cmd_t cmd,
  input  wire logic [EW-1:0]    up_i,
  input  wire logic [EW-1:0]    dn_i,
  output logic [EW-1:0]         q_o
);
  import mrb_pkg::*;

  logic [EW-1:0] ent_r;
  logic [EW-1:0] ent_nxt;

  always_comb begin
    priority if (cmd.push) begin
      ent_nxt = up_i;
    end else if (cmd.pop) begin
      ent_nxt = dn_i;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign q_o = ent_r;
endmodule
`default_nettype wire
